/* sv/resp2_command_parser_top_defines.svh */
// Assertion macros for the RESP2 command parser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RESP2_COMMAND_PARSER_TOP_DEFINES_SVH
`define RESP2_COMMAND_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RCP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcp check failed");
// next-cycle implication
`define RCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcp check failed");
`else
`define RCP_ASSERT_SAME(label, clk, rst, ante, cons)
`define RCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/rcp_pkg.sv */
// Shared types, codes and constants of the RESP2 command parser.
// No dependencies; used by every module of the block.
package rcp_pkg;

   localparam int RCP_ARG_LIMIT = 1024;
   localparam logic [10:0] RCP_COUNT_CAP = 11'(RCP_ARG_LIMIT < 1024 ? RCP_ARG_LIMIT : 1024);

   localparam int RCP_DEC_W = 63;

   // parser phases
   localparam logic [3:0] PH_STAR     = 4'd0;
   localparam logic [3:0] PH_COUNT    = 4'd1;
   localparam logic [3:0] PH_COUNT_LF = 4'd2;
   localparam logic [3:0] PH_DOLLAR   = 4'd3;
   localparam logic [3:0] PH_LEN      = 4'd4;
   localparam logic [3:0] PH_LEN_LF   = 4'd5;
   localparam logic [3:0] PH_PAYLOAD  = 4'd6;
   localparam logic [3:0] PH_CR       = 4'd7;
   localparam logic [3:0] PH_LF       = 4'd8;
   localparam logic [3:0] PH_ERROR    = 4'd9;

   // result kinds
   localparam logic [2:0] KIND_FRAMING  = 3'd0;
   localparam logic [2:0] KIND_HEADER   = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
   localparam logic [2:0] KIND_COMPLETE = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;
   localparam logic [2:0] KIND_IGNORED  = 3'd5;

   // error codes
   localparam logic [3:0] ERR_NOT_STAR    = 4'd0;
   localparam logic [3:0] ERR_BAD_DIGIT   = 4'd1;
   localparam logic [3:0] ERR_OVERFLOW    = 4'd2;
   localparam logic [3:0] ERR_EMPTY       = 4'd3;
   localparam logic [3:0] ERR_MISSING_LF  = 4'd4;
   localparam logic [3:0] ERR_BAD_COUNT   = 4'd5;
   localparam logic [3:0] ERR_NOT_DOLLAR  = 4'd6;
   localparam logic [3:0] ERR_BAD_LENGTH  = 4'd7;
   localparam logic [3:0] ERR_NO_CRLF     = 4'd8;

   // csr register indexes
   localparam logic CSR_MAX_ARGS = 1'b0;
   localparam logic CSR_MAX_LEN  = 1'b1;

   // characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [9:0]  arg_index;
      logic [31:0] arg_length;
      logic        last_in_argument;
      logic [10:0] arg_count;
      logic [31:0] consumed_bytes;
      logic [3:0]  error_code;
   } rcp_result_type;

endpackage

/* sv/resp2_command_parser_top.sv */
// RESP2 command parser, top level: request/response stream ports and csr port.
// Depends on rcp_pkg, rcp_parse_core and rcp_out_buffer.
//
// Takes one request byte per clock and returns exactly one response per byte,
// classifying it as framing, argument header, payload byte, command complete,
// error (with code) or ignored. A request is taken in every cycle as long as
// the two-entry response buffer is not full; the response is registered in the
// buffer before it appears on rsp_. The parse state and decimal accumulator
// update in the same cycle the byte is taken, so the sustained rate is one byte
// per clock, set by the single multiply-by-ten add on the 63-bit accumulator.
// Errors latch until a request with restart set. csr writes are always ready
// and should be made only while the parser is idle. No startup sweep after reset.
module resp2_command_parser_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] restart
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // payload_byte, arg_index, arg_length, arg_count,
                                      // consumed_bytes, error_code, zero pad
   output logic [2:0]    rsp_tuser,   // [2:0] kind
   output logic          rsp_tlast,   // last_in_argument
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);

   logic                    req_accept;
   rcp_pkg::rcp_result_type core_result;
   rcp_pkg::rcp_result_type buf_result;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   rcp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_tdata),
      .restart   (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (core_result)
   );

   rcp_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  (core_result),
      .push_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (buf_result)
   );

   assign rsp_tuser = buf_result.kind;
   assign rsp_tlast = buf_result.last_in_argument;
   assign rsp_tdata = {7'b0,
                       buf_result.error_code,
                       buf_result.consumed_bytes,
                       buf_result.arg_count,
                       buf_result.arg_length,
                       buf_result.arg_index,
                       buf_result.payload_byte};

endmodule

/* sv/rcp_parse_core.sv */
// Parser state, configuration registers and per-byte result logic.
// Depends on rcp_pkg and resp2_command_parser_top_defines.svh.
`include "resp2_command_parser_top_defines.svh"

module rcp_parse_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    restart,
   input  logic                    csr_valid,
   input  logic                    csr_index,
   input  logic [31:0]             csr_data,
   output rcp_pkg::rcp_result_type result
);

   logic [3:0]  phase_ff, phase_in;
   logic [62:0] dec_ff, dec_in;
   logic        minus_ff, minus_in;
   logic        digit_ff, digit_in;
   logic [10:0] args_exp_ff, args_exp_in;
   logic [9:0]  arg_pos_ff, arg_pos_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] cur_len_ff, cur_len_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [10:0] max_args_ff;
   logic [31:0] max_len_ff;

   // decimal digit datapath
   logic        is_digit;
   logic [3:0]  digit;
   logic [66:0] dec_wide;
   logic [66:0] mac;
   logic        ovf;
   logic        num_cr;
   logic        num_minus;
   logic        num_err;
   logic [3:0]  num_code;
   logic [10:0] count_limit;
   logic        bad_count;
   logic        bad_len;
   logic [31:0] cmd_inc;
   logic        last_arg;

   assign is_digit  = (data_byte >= rcp_pkg::CH_ZERO) && (data_byte <= rcp_pkg::CH_NINE);
   assign digit     = 4'(data_byte - rcp_pkg::CH_ZERO);
   assign dec_wide  = {4'b0, dec_ff};
   assign mac       = (dec_wide << 3) + (dec_wide << 1) + {63'b0, digit};
   assign ovf       = (mac[66:63] != 4'b0);
   assign num_cr    = (data_byte == rcp_pkg::CH_CR);
   assign num_minus = (data_byte == rcp_pkg::CH_MINUS) && !minus_ff && !digit_ff;
   assign num_err   = num_cr ? !digit_ff : (!num_minus && (!is_digit || ovf));
   assign num_code  = num_cr ? rcp_pkg::ERR_EMPTY :
                      (!is_digit ? rcp_pkg::ERR_BAD_DIGIT : rcp_pkg::ERR_OVERFLOW);

   assign count_limit = (max_args_ff > rcp_pkg::RCP_COUNT_CAP) ? rcp_pkg::RCP_COUNT_CAP
                                                              : max_args_ff;
   assign bad_count = (dec_ff == 63'b0) || minus_ff || (dec_ff[62:11] != 52'b0) ||
                      (dec_ff[10:0] > count_limit);
   assign bad_len   = (minus_ff && (dec_ff != 63'b0)) || (dec_ff[62:32] != 31'b0) ||
                      (dec_ff[31:0] > max_len_ff);
   assign cmd_inc   = (cmd_ff == 32'hFFFF_FFFF) ? cmd_ff : cmd_ff + 32'd1;
   assign last_arg  = ({1'b0, arg_pos_ff} + 11'd1) >= args_exp_ff;

   always_comb begin
      phase_in    = phase_ff;
      dec_in      = dec_ff;
      minus_in    = minus_ff;
      digit_in    = digit_ff;
      args_exp_in = args_exp_ff;
      arg_pos_in  = arg_pos_ff;
      left_in     = left_ff;
      cur_len_in  = cur_len_ff;
      cmd_in      = cmd_ff;
      result      = '0;
      result.kind = rcp_pkg::KIND_IGNORED;

      if (accept) begin
         if (restart) begin
            phase_in    = rcp_pkg::PH_STAR;
            dec_in      = '0;
            minus_in    = 1'b0;
            digit_in    = 1'b0;
            args_exp_in = '0;
            arg_pos_in  = '0;
            left_in     = '0;
            cur_len_in  = '0;
            cmd_in      = '0;
         end else if (phase_ff >= rcp_pkg::PH_ERROR) begin
            phase_in = rcp_pkg::PH_ERROR;
         end else begin
            cmd_in      = cmd_inc;
            result.kind = rcp_pkg::KIND_FRAMING;
            unique case (phase_ff)
               rcp_pkg::PH_STAR: begin
                  if (data_byte != rcp_pkg::CH_STAR) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = rcp_pkg::ERR_NOT_STAR;
                  end else begin
                     dec_in   = '0;
                     minus_in = 1'b0;
                     digit_in = 1'b0;
                     phase_in = rcp_pkg::PH_COUNT;
                  end
               end
               rcp_pkg::PH_COUNT, rcp_pkg::PH_LEN: begin
                  if (num_err) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = num_code;
                  end else if (num_cr) begin
                     phase_in = (phase_ff == rcp_pkg::PH_COUNT) ? rcp_pkg::PH_COUNT_LF
                                                                 : rcp_pkg::PH_LEN_LF;
                  end else if (num_minus) begin
                     minus_in = 1'b1;
                  end else begin
                     dec_in   = mac[62:0];
                     digit_in = 1'b1;
                  end
               end
               rcp_pkg::PH_COUNT_LF: begin
                  if (data_byte != rcp_pkg::CH_LF || bad_count) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = (data_byte != rcp_pkg::CH_LF) ?
                                         rcp_pkg::ERR_MISSING_LF : rcp_pkg::ERR_BAD_COUNT;
                  end else begin
                     args_exp_in = dec_ff[10:0];
                     arg_pos_in  = '0;
                     phase_in    = rcp_pkg::PH_DOLLAR;
                  end
               end
               rcp_pkg::PH_DOLLAR: begin
                  if (data_byte != rcp_pkg::CH_DOLLAR) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = rcp_pkg::ERR_NOT_DOLLAR;
                  end else begin
                     dec_in   = '0;
                     minus_in = 1'b0;
                     digit_in = 1'b0;
                     phase_in = rcp_pkg::PH_LEN;
                  end
               end
               rcp_pkg::PH_LEN_LF: begin
                  if (data_byte != rcp_pkg::CH_LF || bad_len) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = (data_byte != rcp_pkg::CH_LF) ?
                                         rcp_pkg::ERR_MISSING_LF : rcp_pkg::ERR_BAD_LENGTH;
                  end else begin
                     cur_len_in        = dec_ff[31:0];
                     left_in           = dec_ff[31:0];
                     phase_in          = (dec_ff[31:0] != 32'b0) ? rcp_pkg::PH_PAYLOAD
                                                                 : rcp_pkg::PH_CR;
                     result.kind       = rcp_pkg::KIND_HEADER;
                     result.arg_index  = arg_pos_ff;
                     result.arg_length = dec_ff[31:0];
                  end
               end
               rcp_pkg::PH_PAYLOAD: begin
                  result.kind         = rcp_pkg::KIND_PAYLOAD;
                  result.payload_byte = data_byte;
                  result.arg_index    = arg_pos_ff;
                  result.arg_length   = cur_len_ff;
                  if (left_ff <= 32'd1) begin
                     result.last_in_argument = 1'b1;
                     left_in  = '0;
                     phase_in = rcp_pkg::PH_CR;
                  end else begin
                     left_in = left_ff - 32'd1;
                  end
               end
               rcp_pkg::PH_CR: begin
                  if (data_byte != rcp_pkg::CH_CR) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = rcp_pkg::ERR_NO_CRLF;
                  end else begin
                     phase_in = rcp_pkg::PH_LF;
                  end
               end
               default: begin
                  // trailing LF of an argument
                  if (data_byte != rcp_pkg::CH_LF) begin
                     phase_in          = rcp_pkg::PH_ERROR;
                     result.kind       = rcp_pkg::KIND_ERROR;
                     result.error_code = rcp_pkg::ERR_NO_CRLF;
                  end else if (last_arg) begin
                     result.kind           = rcp_pkg::KIND_COMPLETE;
                     result.arg_count      = args_exp_ff;
                     result.consumed_bytes = cmd_inc;
                     phase_in    = rcp_pkg::PH_STAR;
                     dec_in      = '0;
                     minus_in    = 1'b0;
                     digit_in    = 1'b0;
                     args_exp_in = '0;
                     arg_pos_in  = '0;
                     left_in     = '0;
                     cur_len_in  = '0;
                     cmd_in      = '0;
                  end else begin
                     arg_pos_in = arg_pos_ff + 10'd1;
                     phase_in   = rcp_pkg::PH_DOLLAR;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rcp_pkg::PH_STAR;
         dec_ff      <= '0;
         minus_ff    <= 1'b0;
         digit_ff    <= 1'b0;
         args_exp_ff <= '0;
         arg_pos_ff  <= '0;
         left_ff     <= '0;
         cur_len_ff  <= '0;
         cmd_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         dec_ff      <= dec_in;
         minus_ff    <= minus_in;
         digit_ff    <= digit_in;
         args_exp_ff <= args_exp_in;
         arg_pos_ff  <= arg_pos_in;
         left_ff     <= left_in;
         cur_len_ff  <= cur_len_in;
         cmd_ff      <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= 11'd64;
         max_len_ff  <= 32'd1048576;
      end else if (csr_valid) begin
         if (csr_index == rcp_pkg::CSR_MAX_ARGS) begin
            max_args_ff <= csr_data[10:0];
         end else begin
            max_len_ff <= csr_data;
         end
      end
   end

   `RCP_ASSERT_NEXT(a_error_latches, clock, reset,
      accept && !restart && (phase_ff == rcp_pkg::PH_ERROR), phase_ff == rcp_pkg::PH_ERROR)
   `RCP_ASSERT_NEXT(a_restart_clears, clock, reset,
      accept && restart, (phase_ff == rcp_pkg::PH_STAR) && (cmd_ff == 32'b0))
   `RCP_ASSERT_SAME(a_arg_in_range, clock, reset,
      phase_ff == rcp_pkg::PH_PAYLOAD, {1'b0, arg_pos_ff} < args_exp_ff)

endmodule

/* sv/rcp_out_buffer.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on rcp_pkg and resp2_command_parser_top_defines.svh.
`include "resp2_command_parser_top_defines.svh"

module rcp_out_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rcp_pkg::rcp_result_type push_data,
   output logic                    push_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rcp_pkg::rcp_result_type rsp_data
);

   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   rcp_pkg::rcp_result_type out_data_ff, out_data_in;
   rcp_pkg::rcp_result_type skid_data_ff, skid_data_in;
   logic                    slot_free;

   assign slot_free  = !out_valid_ff || rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (slot_free) begin
         // skid entry goes first; no push can arrive while it is full
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `RCP_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RCP_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      push && out_valid_ff && !rsp_ready, skid_valid_ff && out_valid_ff)

endmodule

/* tb/resp2_parse_checker.sv */
// Scoreboard for the RESP2 command parser: watches the request, response and csr channels,
// predicts one response per accepted request byte and compares it field by field.
// Depends on rcp_pkg for result layout, phase, kind, error and csr codes.
`timescale 1ns / 100ps

module resp2_parse_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [103:0]  rsp_tdata,
   input  logic [2:0]    rsp_tuser,
   input  logic          rsp_tlast,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic          csr_index,
   input  logic [31:0]   csr_data,
   output int            mismatches,
   output int            pending
);
   import rcp_pkg::*;

   localparam logic [63:0] DEC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // parser model state
   logic [3:0]  phase;
   logic [62:0] accum;
   logic        neg_seen;
   logic        digit_seen;
   logic [10:0] args_total;
   logic [9:0]  arg_pos;
   logic [31:0] bytes_left;
   logic [31:0] arg_len;
   logic [31:0] cmd_bytes;
   logic [10:0] max_args_cfg;
   logic [31:0] max_len_cfg;

   rcp_result_type expected_q[$];
   rcp_result_type got_r;
   rcp_result_type want_r;

   function automatic void restart_parser();
      phase = PH_STAR;
      accum = '0;
      neg_seen = 1'b0;
      digit_seen = 1'b0;
      args_total = '0;
      arg_pos = '0;
      bytes_left = '0;
      arg_len = '0;
      cmd_bytes = '0;
   endfunction

   function automatic void clear_accum();
      accum = '0;
      neg_seen = 1'b0;
      digit_seen = 1'b0;
   endfunction

   function automatic void flag_error(inout rcp_result_type r, input logic [3:0] code);
      phase = PH_ERROR;
      r.kind = KIND_ERROR;
      r.error_code = code;
   endfunction

   // 0: digit or sign taken, 1: CR closing a valid number, -1: error raised
   function automatic int number_char(input logic [7:0] b, inout rcp_result_type r);
      logic [63:0] digit;
      digit = 64'(8'(b - CH_ZERO));
      if (b == CH_CR) begin
         if (!digit_seen) begin
            flag_error(r, ERR_EMPTY);
            return -1;
         end
         return 1;
      end
      if (b == CH_MINUS && !neg_seen && !digit_seen) begin
         neg_seen = 1'b1;
         return 0;
      end
      if (b < CH_ZERO || b > CH_NINE) begin
         flag_error(r, ERR_BAD_DIGIT);
         return -1;
      end
      if ({1'b0, accum} > (DEC_MAX - digit) / 64'd10) begin
         flag_error(r, ERR_OVERFLOW);
         return -1;
      end
      accum = 63'({1'b0, accum} * 64'd10 + digit);
      digit_seen = 1'b1;
      return 0;
   endfunction

   function automatic rcp_result_type predict_byte(input logic [7:0] b, input logic rs);
      rcp_result_type r;
      logic [10:0] cap;
      int st;
      r = '0;
      if (rs) begin
         restart_parser();
         r.kind = KIND_IGNORED;
         return r;
      end
      // latched error: everything is ignored until restart
      if (phase == PH_ERROR || phase > PH_LF) begin
         phase = PH_ERROR;
         r.kind = KIND_IGNORED;
         return r;
      end
      if (cmd_bytes != '1)
         cmd_bytes = cmd_bytes + 32'd1;
      r.kind = KIND_FRAMING;
      case (phase)
         PH_STAR: begin
            if (b != CH_STAR)
               flag_error(r, ERR_NOT_STAR);
            else begin
               clear_accum();
               phase = PH_COUNT;
            end
         end
         PH_COUNT: begin
            st = number_char(b, r);
            if (st > 0)
               phase = PH_COUNT_LF;
         end
         PH_COUNT_LF: begin
            cap = (max_args_cfg > RCP_COUNT_CAP) ? RCP_COUNT_CAP : max_args_cfg;
            if (b != CH_LF)
               flag_error(r, ERR_MISSING_LF);
            else if (accum == '0 || neg_seen || accum > 63'(cap))
               flag_error(r, ERR_BAD_COUNT);
            else begin
               args_total = accum[10:0];
               arg_pos = '0;
               phase = PH_DOLLAR;
            end
         end
         PH_DOLLAR: begin
            if (b != CH_DOLLAR)
               flag_error(r, ERR_NOT_DOLLAR);
            else begin
               clear_accum();
               phase = PH_LEN;
            end
         end
         PH_LEN: begin
            st = number_char(b, r);
            if (st > 0)
               phase = PH_LEN_LF;
         end
         PH_LEN_LF: begin
            if (b != CH_LF)
               flag_error(r, ERR_MISSING_LF);
            else if ((neg_seen && accum != '0) || accum > 63'(max_len_cfg))
               flag_error(r, ERR_BAD_LENGTH);
            else begin
               arg_len = accum[31:0];
               bytes_left = arg_len;
               phase = (bytes_left != '0) ? PH_PAYLOAD : PH_CR;
               r.kind = KIND_HEADER;
               r.arg_index = arg_pos;
               r.arg_length = arg_len;
            end
         end
         PH_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.arg_index = arg_pos;
            r.arg_length = arg_len;
            if (bytes_left <= 32'd1) begin
               r.last_in_argument = 1'b1;
               bytes_left = '0;
               phase = PH_CR;
            end else
               bytes_left = bytes_left - 32'd1;
         end
         PH_CR: begin
            if (b != CH_CR)
               flag_error(r, ERR_NO_CRLF);
            else
               phase = PH_LF;
         end
         default: begin
            if (b != CH_LF)
               flag_error(r, ERR_NO_CRLF);
            else if (32'(arg_pos) + 32'd1 >= 32'(args_total)) begin
               r.kind = KIND_COMPLETE;
               r.arg_count = args_total;
               r.consumed_bytes = cmd_bytes;
               restart_parser();
            end else begin
               arg_pos = arg_pos + 10'd1;
               phase = PH_DOLLAR;
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_parser();
         max_args_cfg = 11'd64;
         max_len_cfg = 32'd1048576;
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r.kind = rsp_tuser;
            got_r.payload_byte = rsp_tdata[7:0];
            got_r.arg_index = rsp_tdata[17:8];
            got_r.arg_length = rsp_tdata[49:18];
            got_r.last_in_argument = rsp_tlast;
            got_r.arg_count = rsp_tdata[60:50];
            got_r.consumed_bytes = rsp_tdata[92:61];
            got_r.error_code = rsp_tdata[96:93];
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request outstanding, expected none, actual %h",
                        $time, got_r);
            end else begin
               want_r = expected_q.pop_front();
               check_field("kind", 64'(want_r.kind), 64'(got_r.kind));
               check_field("payload_byte", 64'(want_r.payload_byte), 64'(got_r.payload_byte));
               check_field("arg_index", 64'(want_r.arg_index), 64'(got_r.arg_index));
               check_field("arg_length", 64'(want_r.arg_length), 64'(got_r.arg_length));
               check_field("last_in_argument", 64'(want_r.last_in_argument),
                           64'(got_r.last_in_argument));
               check_field("arg_count", 64'(want_r.arg_count), 64'(got_r.arg_count));
               check_field("consumed_bytes", 64'(want_r.consumed_bytes),
                           64'(got_r.consumed_bytes));
               check_field("error_code", 64'(want_r.error_code), 64'(got_r.error_code));
               check_field("tdata pad", 64'd0, 64'(rsp_tdata[103:97]));
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_byte(req_tdata, req_tuser));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_ARGS)
               max_args_cfg = csr_data[10:0];
            else if (csr_index == CSR_MAX_LEN)
               max_len_cfg = csr_data;
         end
      end
      pending = expected_q.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for resp2_command_parser_top: clock, reset, request stimulus, response
// back-pressure, csr writes and the verdict. Depends on rcp_pkg and resp2_parse_checker.
`timescale 1ns / 100ps

module tb;
   import rcp_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_index = CSR_MAX_ARGS;
   logic [31:0]   csr_data = 32'd0;

   int mismatches;
   int pending;

   int send_idle_pct = 36;
   int recv_idle_pct = 48;
   int stall_left = 0;
   int parsed_items = 0;
   int lim_args = 64;
   longint unsigned lim_len = 1048576;

   // {restart, byte} requests waiting to be sent
   logic [8:0] stream[$];

   always #5 clock = ~clock;

   resp2_command_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   resp2_parse_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // receiver: random back-pressure, or a long hold-off while stall_left runs down
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input logic [8:0] item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item[7:0];
      req_tuser <= item[8];
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      if (!item[8])
         parsed_items++;
   endtask

   task automatic flush_stream();
      while (stream.size() > 0)
         send_item(stream.pop_front());
   endtask

   // '^' stands for CR and '~' for LF
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] == "^")
            stream.push_back({1'b0, CH_CR});
         else if (s[i] == "~")
            stream.push_back({1'b0, CH_LF});
         else
            stream.push_back({1'b0, 8'(s[i])});
      end
   endtask

   task automatic add_restart();
      stream.push_back({1'b1, 8'($urandom)});
   endtask

   task automatic add_number(input longint unsigned v, input bit neg);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(7) == 0)
         s = {"0", s};
      if (neg)
         s = {"-", s};
      add_text(s);
   endtask

   task automatic add_digits(input int n);
      stream.push_back({1'b0, 8'(CH_ZERO + $urandom_range(1, 9))});
      repeat (n - 1)
         stream.push_back({1'b0, 8'(CH_ZERO + $urandom_range(9))});
   endtask

   task automatic add_argument(input longint unsigned len);
      add_text("$");
      add_number(len, len == 0 && $urandom_range(3) == 0);
      add_text("^~");
      repeat (len)
         stream.push_back({1'b0, 8'($urandom)});
      add_text("^~");
   endtask

   task automatic add_command(input int nargs, input int max_plen);
      add_text("*");
      add_number(nargs, 1'b0);
      add_text("^~");
      repeat (nargs)
         add_argument($urandom_range(max_plen));
   endtask

   task automatic random_command();
      int lim;
      int plen;
      int mode;
      int nargs;
      int cut;
      int pick;
      lim = (lim_args < 1024) ? lim_args : 1024;
      plen = (lim_len < 6) ? int'(lim_len) : 6;
      mode = $urandom_range(99);
      nargs = $urandom_range(1, (lim < 4) ? lim : 4);
      if ($urandom_range(29) == 0 && lim <= 64)
         nargs = lim;
      if (mode < 62)
         add_command(nargs, plen);
      else if (mode < 74) begin
         // well-formed command, then one byte corrupted or the tail cut off
         add_command(nargs, plen);
         cut = $urandom_range(stream.size() - 1);
         if ($urandom_range(1))
            stream[cut] = {1'b0, 8'($urandom)};
         else
            while (stream.size() > cut)
               stream.delete(stream.size() - 1);
         add_restart();
      end else if (mode < 82) begin
         add_text("*");
         pick = $urandom_range(2);
         if (pick == 0)
            add_number(0, $urandom_range(1));
         else if (pick == 1)
            add_number($urandom_range(1, 9), 1'b1);
         else
            add_number(lim + $urandom_range(1, 3), 1'b0);
         add_text("^~");
         add_restart();
      end else if (mode < 90) begin
         add_text("*1^~$");
         pick = $urandom_range(2);
         if (pick == 0)
            add_number($urandom_range(1, 99), 1'b1);
         else if (pick == 1) begin
            if (lim_len != 64'hFFFF_FFFF)
               add_number(lim_len + $urandom_range(1, 3), 1'b0);
            else
               add_number(64'h1_0000_0000 + $urandom, 1'b0);
         end else
            add_number(lim_len - ((lim_len < 3) ? lim_len : $urandom_range(2)), 1'b0);
         add_text("^~");
         if (pick == 2)
            repeat (3)
               stream.push_back({1'b0, 8'($urandom)});
         add_restart();
      end else if (mode < 95) begin
         add_text("*");
         if ($urandom_range(1))
            add_text("1^~$");
         add_digits($urandom_range(18, 21));
         add_text("^~");
         add_restart();
      end else begin
         repeat ($urandom_range(1, 8))
            stream.push_back({1'b0, 8'($urandom)});
         add_restart();
      end
      flush_stream();
   endtask

   task automatic run_random(input int count);
      int stop;
      stop = parsed_items + count;
      while (parsed_items < stop)
         random_command();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_limits(input int args, input longint unsigned len);
      drain();
      repeat (2)
         @(negedge clock);
      write_reg(CSR_MAX_ARGS, 32'(args));
      write_reg(CSR_MAX_LEN, 32'(len));
      csr_valid <= 1'b0;
      lim_args = args;
      lim_len = len;
   endtask

   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (5)
         @(negedge clock);
      reset <= 1'b0;

      // directed cases at the reset limits (64 arguments, 1 MiB)
      add_text("*1^~$4^~PING^~");
      add_text("*2^~$-0^~^~$1^~");
      stream.push_back({1'b0, 8'hFF});
      add_text("^~");
      add_text("*1^~$0^~^~*1^~$2^~hi^~");
      add_text("*1^~$2^^~^~^~");
      add_text("XY");
      add_restart();
      add_text("*1a");
      add_restart();
      add_text("*1-");
      add_restart();
      add_text("*^");
      add_restart();
      add_text("*1^X");
      add_restart();
      add_text("*0^~");
      add_restart();
      add_text("*-0^~");
      add_restart();
      add_text("*-1^~");
      add_restart();
      add_text("*65^~");
      add_restart();
      add_text("*64^~");
      add_restart();
      add_text("*9223372036854775807^~");
      add_restart();
      add_text("*1^~$92233720368547758070");
      add_restart();
      add_text("*1^~$1048577^~");
      add_restart();
      add_text("*1^~$1048576^~");
      add_restart();
      add_text("*1^~X");
      add_restart();
      add_text("*1^~$-1^~");
      add_restart();
      add_text("*1^~$1^~AB");
      add_restart();
      add_text("*1^~$1^~A^B");
      add_restart();
      flush_stream();

      run_random(200);
      drain();
      run_random(200);

      set_limits(1, 0);
      run_random(300);

      send_idle_pct = 48;
      recv_idle_pct = 36;
      set_limits(1024, 64'hFFFF_FFFF);
      run_random(400);

      // long receiver hold-off while requests keep coming
      set_limits(3, 5);
      stall_left = 400;
      run_random(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_limits(1024, 64'hFFFF_FFFF);
      // largest count accepted, first argument taken, then abandoned
      add_text("*1024^~$0^~^~");
      add_restart();
      flush_stream();
      run_random(200);

      drain();
      repeat (10)
         @(negedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/rcp_pkg.sv
sv/rcp_parse_core.sv
sv/rcp_out_buffer.sv
sv/resp2_command_parser_top.sv
tb/resp2_parse_checker.sv
tb/tb.sv
